FILE: sv/sabc_pkg.sv
// Shared constants, register indexes and result type for the sensor alarm buzzer controller.
package sabc_pkg;

    // Field widths
    localparam int unsigned CntW     = 16;
    localparam int unsigned TempW    = 13;
    localparam int unsigned MvW      = 12;
    localparam int unsigned IvW      = 10;
    localparam int unsigned AlertW   = 3;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 16;

    // Configuration register indexes
    localparam logic [CfgAddrW-1:0] REG_FAST_PERIOD = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_TEMP_PERIOD = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_SOUND_HOLD  = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_TEMP_LOW    = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_TEMP_HIGH   = 3'd4;

    // Configuration reset values
    localparam logic [CntW-1:0]         FAST_PERIOD_RST = 16'd100;
    localparam logic [CntW-1:0]         TEMP_PERIOD_RST = 16'd2000;
    localparam logic [CntW-1:0]         SOUND_HOLD_RST  = 16'd3000;
    localparam logic signed [TempW-1:0] TEMP_LOW_RST    = 13'sd100;
    localparam logic signed [TempW-1:0] TEMP_HIGH_RST   = 13'sd300;

    // Beep intervals by alert priority
    localparam logic [IvW-1:0] BEEP_SOUND = 10'd400;
    localparam logic [IvW-1:0] BEEP_HOT   = 10'd1000;
    localparam logic [IvW-1:0] BEEP_COLD  = 10'd600;
    localparam logic [IvW-1:0] BEEP_NONE  = 10'd0;

    // Sensor offset: 500 mV reads as zero degrees
    localparam logic signed [TempW-1:0] ZERO_MV = 13'sd500;

    // Saturation value of the millisecond counters
    localparam logic [CntW-1:0] CNT_MAX = 16'hFFFF;

    // Input kinds (tuser)
    localparam logic ACT_TICK     = 1'b0;
    localparam logic ACT_OVERRIDE = 1'b1;

    // Alert bit positions
    localparam int unsigned ALERT_SOUND = 0;
    localparam int unsigned ALERT_HOT   = 1;
    localparam int unsigned ALERT_COLD  = 2;

    // One result item, last field in the lowest bits
    typedef struct packed {
        logic                    sound_seen;
        logic signed [TempW-1:0] temperature_x10;
        logic [IvW-1:0]          beep_interval_ms;
        logic [AlertW-1:0]       alerts;
        logic                    buzzer;
    } result_t;

    localparam int unsigned ResW    = $bits(result_t);
    localparam int unsigned OutDataW = ((ResW + 7) / 8) * 8;

endpackage

FILE: sv/sensor_alarm_buzzer_controller_top.sv
// Sensor alarm and buzzer controller: timers, alert logic, buzzer drive and output buffer.
// A result item is registered in the result register, or in the skid entry while that register holds a waiting item.
// Throughput: one item per cycle while tready is high; counter, compare and select logic feeds the result register.
// A skid entry behind the result register holds one item during an output stall; tready
// drops only while the skid entry is occupied.
// Reset (rst_n, async, active low) clears counters and flags, loads register defaults
// and arms the first-tick sample.
module sensor_alarm_buzzer_controller_top
    import sabc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // mic_level, sensor_mv, override_enable, override_level
    input  logic                s_tuser,   // action
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // buzzer, alerts, beep_interval_ms, temperature_x10, sound_seen
    // configuration write port
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_data
);

    // Configuration registers
    logic [CntW-1:0]         fast_period_reg;
    logic [CntW-1:0]         temp_period_reg;
    logic [CntW-1:0]         sound_hold_reg;
    logic signed [TempW-1:0] temp_low_reg;
    logic signed [TempW-1:0] temp_high_reg;

    // Block state
    logic [CntW-1:0]         fast_elapsed_reg, fast_elapsed_next;
    logic [CntW-1:0]         temp_elapsed_reg, temp_elapsed_next;
    logic [CntW-1:0]         hold_left_reg, hold_left_next;
    logic [CntW-1:0]         toggle_elapsed_reg, toggle_elapsed_next;
    logic signed [TempW-1:0] temperature_reg, temperature_next;
    logic                    sound_flag_reg, sound_flag_next;
    logic [AlertW-1:0]       alert_bits_reg, alert_bits_next;
    logic [IvW-1:0]          interval_reg, interval_next;
    logic                    buzzer_level_reg, buzzer_level_next;
    logic                    override_on_reg, override_on_next;
    logic                    override_value_reg, override_value_next;
    logic                    first_pending_reg, first_pending_next;

    // Output buffer
    result_t                 out_reg, skid_reg, res_next;
    logic                    out_valid_reg, skid_valid_reg;

    // Input fields
    logic                    in_mic_level;
    logic [MvW-1:0]          in_sensor_mv;
    logic                    in_override_enable;
    logic                    in_override_level;
    logic                    accept;
    logic                    out_fire;

    assign in_mic_level       = s_tdata[0];
    assign in_sensor_mv       = s_tdata[12:1];
    assign in_override_enable = s_tdata[13];
    assign in_override_level  = s_tdata[14];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_fire = out_valid_reg && m_tready;
    assign m_tdata  = {{(OutDataW - ResW){1'b0}}, out_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_period_reg <= FAST_PERIOD_RST;
            temp_period_reg <= TEMP_PERIOD_RST;
            sound_hold_reg  <= SOUND_HOLD_RST;
            temp_low_reg    <= TEMP_LOW_RST;
            temp_high_reg   <= TEMP_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FAST_PERIOD: fast_period_reg <= cfg_data;
                REG_TEMP_PERIOD: temp_period_reg <= cfg_data;
                REG_SOUND_HOLD:  sound_hold_reg  <= cfg_data;
                REG_TEMP_LOW:    temp_low_reg    <= cfg_data[TempW-1:0];
                REG_TEMP_HIGH:   temp_high_reg   <= cfg_data[TempW-1:0];
                default:         ;
            endcase
        end
    end

    // Per-item next state: timers, fast sample, alerts, override, buzzer
    always_comb
    begin
        logic [CntW-1:0]   fe_inc, te_inc, tg_inc, hl_dec;
        logic              do_sample, do_temp;
        logic [AlertW-1:0] flags;

        fast_elapsed_next   = fast_elapsed_reg;
        temp_elapsed_next   = temp_elapsed_reg;
        hold_left_next      = hold_left_reg;
        toggle_elapsed_next = toggle_elapsed_reg;
        temperature_next    = temperature_reg;
        sound_flag_next     = sound_flag_reg;
        alert_bits_next     = alert_bits_reg;
        interval_next       = interval_reg;
        override_on_next    = override_on_reg;
        override_value_next = override_value_reg;
        first_pending_next  = first_pending_reg;
        flags               = '0;

        fe_inc = (fast_elapsed_reg == CNT_MAX) ? CNT_MAX : fast_elapsed_reg + 16'd1;
        te_inc = (temp_elapsed_reg == CNT_MAX) ? CNT_MAX : temp_elapsed_reg + 16'd1;
        tg_inc = (toggle_elapsed_reg == CNT_MAX) ? CNT_MAX : toggle_elapsed_reg + 16'd1;
        hl_dec = (hold_left_reg != '0) ? hold_left_reg - 16'd1 : '0;

        do_sample = first_pending_reg || (fe_inc >= fast_period_reg);
        do_temp   = first_pending_reg || (te_inc >= temp_period_reg);

        if (s_tuser == ACT_TICK)
        begin
            fast_elapsed_next   = fe_inc;
            temp_elapsed_next   = te_inc;
            toggle_elapsed_next = tg_inc;
            hold_left_next      = hl_dec;
            if (do_sample)
            begin
                // microphone is active low; a detection restarts the hold
                sound_flag_next = !in_mic_level;
                if (!in_mic_level)
                    hold_left_next = sound_hold_reg;
                if (do_temp)
                begin
                    temperature_next  = $signed({1'b0, in_sensor_mv}) - ZERO_MV;
                    temp_elapsed_next = '0;
                end
                flags[ALERT_SOUND] = (hold_left_next != '0);
                flags[ALERT_HOT]   = (temperature_next > temp_high_reg);
                flags[ALERT_COLD]  = (temperature_next < temp_low_reg);
                alert_bits_next    = flags;
                // interval by priority: sound, hot, cold
                if (flags[ALERT_SOUND])
                    interval_next = BEEP_SOUND;
                else if (flags[ALERT_HOT])
                    interval_next = BEEP_HOT;
                else if (flags[ALERT_COLD])
                    interval_next = BEEP_COLD;
                else
                    interval_next = BEEP_NONE;
                fast_elapsed_next  = '0;
                first_pending_next = 1'b0;
            end
        end
        else
        begin
            override_on_next    = in_override_enable;
            override_value_next = in_override_level;
        end

        // buzzer drive, after every item
        buzzer_level_next = buzzer_level_reg;
        if (override_on_next)
            buzzer_level_next = override_value_next;
        else if (interval_next == BEEP_NONE)
            buzzer_level_next = 1'b0;
        else if (toggle_elapsed_next >= {{(CntW - IvW){1'b0}}, interval_next})
        begin
            buzzer_level_next   = !buzzer_level_reg;
            toggle_elapsed_next = '0;
        end

        res_next.buzzer           = buzzer_level_next;
        res_next.alerts           = alert_bits_next;
        res_next.beep_interval_ms = interval_next;
        res_next.temperature_x10  = temperature_next;
        res_next.sound_seen       = sound_flag_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_elapsed_reg   <= '0;
            temp_elapsed_reg   <= '0;
            hold_left_reg      <= '0;
            toggle_elapsed_reg <= '0;
            temperature_reg    <= '0;
            sound_flag_reg     <= 1'b0;
            alert_bits_reg     <= '0;
            interval_reg       <= '0;
            buzzer_level_reg   <= 1'b0;
            override_on_reg    <= 1'b0;
            override_value_reg <= 1'b0;
            first_pending_reg  <= 1'b1;
        end
        else if (accept)
        begin
            fast_elapsed_reg   <= fast_elapsed_next;
            temp_elapsed_reg   <= temp_elapsed_next;
            hold_left_reg      <= hold_left_next;
            toggle_elapsed_reg <= toggle_elapsed_next;
            temperature_reg    <= temperature_next;
            sound_flag_reg     <= sound_flag_next;
            alert_bits_reg     <= alert_bits_next;
            interval_reg       <= interval_next;
            buzzer_level_reg   <= buzzer_level_next;
            override_on_reg    <= override_on_next;
            override_value_reg <= override_value_next;
            first_pending_reg  <= first_pending_next;
        end
    end

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res_next;
        end
        else if (accept)
        begin
            skid_reg <= res_next;
        end
    end

    // Skid entry is only ever filled behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty result register");

    // Any accepted tick consumes the first-sample request
    a_first_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == ACT_TICK)) |=> !first_pending_reg)
        else $error("first sample still pending after a tick");

    // Interval is silent exactly when no alert is set
    a_interval_alerts: assert property (@(posedge clk) disable iff (!rst_n)
        (interval_reg == BEEP_NONE) == (alert_bits_reg == '0))
        else $error("beep interval disagrees with alert bits");

    // Without override a silent interval keeps the buzzer off
    a_silent_off: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (override_on_reg || (interval_reg != BEEP_NONE) || !buzzer_level_reg))
        else $error("buzzer on with silent interval and no override");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sensor alarm buzzer controller.
`timescale 1ns / 100ps

module testbench;
    import sabc_pkg::*;

    // Input item payload, laid out as s_tdata from bit 0 up
    typedef struct packed {
        logic        ovr_level;
        logic        ovr_enable;
        logic [11:0] sensor_mv;
        logic        mic_level;
    } item_data_t;

    // Alarm predictor plus the queue of expected result items
    class alarm_scoreboard;
        logic [CntW-1:0]         fast_period;
        logic [CntW-1:0]         temp_period;
        logic [CntW-1:0]         hold_time;
        logic signed [TempW-1:0] low_limit;
        logic signed [TempW-1:0] high_limit;

        logic [CntW-1:0]         fast_ms;
        logic [CntW-1:0]         temp_ms;
        logic [CntW-1:0]         hold_ms;
        logic [CntW-1:0]         toggle_ms;
        logic signed [TempW-1:0] temp_x10;
        logic                    sound;
        logic [AlertW-1:0]       alert_bits;
        logic [IvW-1:0]          beep_ms;
        logic                    buzz;
        logic                    ovr_on;
        logic                    ovr_val;
        logic                    first_tick;

        result_t                 expected_q[$];
        int                      errors;

        function new();
            fast_period = FAST_PERIOD_RST;
            temp_period = TEMP_PERIOD_RST;
            hold_time   = SOUND_HOLD_RST;
            low_limit   = TEMP_LOW_RST;
            high_limit  = TEMP_HIGH_RST;
            fast_ms     = '0;
            temp_ms     = '0;
            hold_ms     = '0;
            toggle_ms   = '0;
            temp_x10    = '0;
            sound       = 1'b0;
            alert_bits  = '0;
            beep_ms     = BEEP_NONE;
            buzz        = 1'b0;
            ovr_on      = 1'b0;
            ovr_val     = 1'b0;
            first_tick  = 1'b1;
            errors      = 0;
        endfunction

        function logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                REG_FAST_PERIOD: fast_period = val;
                REG_TEMP_PERIOD: temp_period = val;
                REG_SOUND_HOLD:  hold_time   = val;
                REG_TEMP_LOW:    low_limit   = val[TempW-1:0];
                REG_TEMP_HIGH:   high_limit  = val[TempW-1:0];
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted item and queue its result
        function void note_input(logic action, item_data_t d);
            result_t r;
            int      t;
            if (action == ACT_TICK) begin
                fast_ms   = sat_inc(fast_ms);
                temp_ms   = sat_inc(temp_ms);
                toggle_ms = sat_inc(toggle_ms);
                if (hold_ms != 0)
                    hold_ms = hold_ms - 1'b1;
                // fast sample: mic, temperature read, alerts, interval
                if (first_tick || fast_ms >= fast_period) begin
                    sound = !d.mic_level;
                    if (sound)
                        hold_ms = hold_time;
                    if (first_tick || temp_ms >= temp_period) begin
                        t        = int'(d.sensor_mv) - 500;
                        temp_x10 = t[TempW-1:0];
                        temp_ms  = '0;
                    end
                    alert_bits              = '0;
                    alert_bits[ALERT_SOUND] = (hold_ms != 0);
                    alert_bits[ALERT_HOT]   = (temp_x10 > high_limit);
                    alert_bits[ALERT_COLD]  = (temp_x10 < low_limit);
                    if (alert_bits[ALERT_SOUND])
                        beep_ms = BEEP_SOUND;
                    else if (alert_bits[ALERT_HOT])
                        beep_ms = BEEP_HOT;
                    else if (alert_bits[ALERT_COLD])
                        beep_ms = BEEP_COLD;
                    else
                        beep_ms = BEEP_NONE;
                    fast_ms    = '0;
                    first_tick = 1'b0;
                end
            end
            else begin
                ovr_on  = d.ovr_enable;
                ovr_val = d.ovr_level;
            end
            // buzzer drive
            if (ovr_on)
                buzz = ovr_val;
            else if (beep_ms == BEEP_NONE)
                buzz = 1'b0;
            else if (toggle_ms >= beep_ms) begin
                buzz      = !buzz;
                toggle_ms = '0;
            end
            r.buzzer           = buzz;
            r.alerts           = alert_bits;
            r.beep_interval_ms = beep_ms;
            r.temperature_x10  = temp_x10;
            r.sound_seen       = sound;
            expected_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.buzzer !== want.buzzer) begin
                $display("%0t: buzzer expected %0d got %0d", $time, want.buzzer, got.buzzer);
                errors++;
            end
            if (got.alerts !== want.alerts) begin
                $display("%0t: alerts expected %b got %b", $time, want.alerts, got.alerts);
                errors++;
            end
            if (got.beep_interval_ms !== want.beep_interval_ms) begin
                $display("%0t: beep_interval_ms expected %0d got %0d", $time,
                         want.beep_interval_ms, got.beep_interval_ms);
                errors++;
            end
            if (got.temperature_x10 !== want.temperature_x10) begin
                $display("%0t: temperature_x10 expected %0d got %0d", $time,
                         want.temperature_x10, got.temperature_x10);
                errors++;
            end
            if (got.sound_seen !== want.sound_seen) begin
                $display("%0t: sound_seen expected %0d got %0d", $time,
                         want.sound_seen, got.sound_seen);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;   // mic_level, sensor_mv, override_enable, override_level
    logic                s_tuser;   // action
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;   // buzzer, alerts, beep_interval_ms, temperature_x10, sound_seen
    logic                cfg_we;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [CfgDataW-1:0] cfg_data;

    alarm_scoreboard sb = new();
    int              hold_req;

    sensor_alarm_buzzer_controller_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Monitor both streams at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, item_data_t'(s_tdata[14:0]));
            if (m_tvalid && m_tready)
                sb.check_result(result_t'(m_tdata[ResW-1:0]));
        end
    end

    // Result side: randomly changing stall patterns, plus one long hold-off
    initial
    begin
        int rx_mode;
        int rx_left;
        int hold_cycles;
        int phase_cnt;
        int holds_seen;
        rx_mode     = 0;
        rx_left     = 0;
        hold_cycles = 0;
        phase_cnt   = 0;
        holds_seen  = 0;
        m_tready    = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req != holds_seen) begin
                holds_seen  = hold_req;
                hold_cycles = 400;
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(64, 256);
            end
            rx_left--;
            phase_cnt++;
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready = 1'b0;
            end
            else begin
                case (rx_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 3) != 0);
                    2: m_tready = ((phase_cnt % 5) < 3);
                    default: m_tready = ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Offer one item and wait until it is taken
    task automatic push_item(input logic action, input item_data_t d);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = action;
        s_tdata  = {1'b0, d};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic idle_sender(input int n);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Stop sending until every expected result is back
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input int val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = val[CfgDataW-1:0];
        sb.write_reg(idx, val[CfgDataW-1:0]);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_all(input int fast, input int temp, input int hold,
                           input int low, input int high);
        write_reg(REG_FAST_PERIOD, fast);
        write_reg(REG_TEMP_PERIOD, temp);
        write_reg(REG_SOUND_HOLD, hold);
        write_reg(REG_TEMP_LOW, low);
        write_reg(REG_TEMP_HIGH, high);
    endtask

    task automatic tick(input logic mic, input int mv);
        item_data_t d;
        d.mic_level  = mic;
        d.sensor_mv  = mv[11:0];
        d.ovr_enable = $urandom_range(0, 1);
        d.ovr_level  = $urandom_range(0, 1);
        push_item(ACT_TICK, d);
    endtask

    task automatic override_cmd(input logic en, input logic lvl);
        item_data_t d;
        d.mic_level  = $urandom_range(0, 1);
        d.sensor_mv  = $urandom_range(0, 4095);
        d.ovr_enable = en;
        d.ovr_level  = lvl;
        push_item(ACT_OVERRIDE, d);
    endtask

    // Random item: mostly ticks with rare sound, some temperature extremes
    task automatic random_item();
        int mv;
        case ($urandom_range(0, 7))
            0: mv = $urandom_range(0, 40);
            1: mv = $urandom_range(4055, 4095);
            default: mv = $urandom_range(0, 4095);
        endcase
        if ($urandom_range(0, 99) < 4)
            override_cmd($urandom_range(0, 2) == 0, $urandom_range(0, 1));
        else
            tick($urandom_range(0, 9) != 0, mv);
    endtask

    // Random traffic in bursts with random gaps
    task automatic random_run(input int n);
        int burst;
        burst = 0;
        repeat (n) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 50);
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 8));
            end
            burst--;
            random_item();
        end
    endtask

    initial
    begin
        int low;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = ACT_TICK;
        s_tdata  = '0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        hold_req = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: first tick samples at once, then overrides at reset settings
        tick(1'b0, 4095);
        tick(1'b1, 0);
        override_cmd(1'b1, 1'b1);
        override_cmd(1'b1, 1'b0);
        override_cmd(1'b0, 1'b1);
        tick(1'b1, 2730);
        drain();

        // Zero periods: sample and read temperature on every tick
        set_all(0, 0, 2, 100, 300);
        tick(1'b1, 0);
        tick(1'b1, 4095);
        tick(1'b1, 500);
        tick(1'b0, 1365);
        tick(1'b1, 2730);
        tick(1'b1, 600);
        tick(1'b1, 4095);
        override_cmd(1'b1, 1'b1);
        tick(1'b1, 0);
        override_cmd(1'b0, 1'b0);
        tick(1'b1, 0);
        drain();

        // Zero hold: sound alert never sets
        write_reg(REG_SOUND_HOLD, 0);
        tick(1'b0, 650);
        tick(1'b0, 4095);
        tick(1'b1, 3);
        drain();

        // Zero periods and extreme limits; long result stall with input pushing
        set_all(0, 0, 0, -4096, 4095);
        hold_req++;
        repeat (40) random_item();
        random_run(240);
        drain();

        set_all(1, 1, 1, -500, 3595);
        random_run(270);
        drain();

        // Inverted limits: hot and cold together
        set_all(2, 65535, 65535, 4095, -4096);
        random_run(270);
        drain();

        set_all(FAST_PERIOD_RST, TEMP_PERIOD_RST, SOUND_HOLD_RST,
                TEMP_LOW_RST, TEMP_HIGH_RST);
        random_run(270);
        drain();

        low = $urandom_range(0, 2000) - 500;
        set_all($urandom_range(1, 8), $urandom_range(0, 30), $urandom_range(0, 900),
                low, $urandom_range(low + 500, 3595));
        random_run(270);
        drain();

        set_all(65535, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 8191), $urandom_range(0, 8191));
        random_run(270);
        drain();

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
